>>> rtl/core/lifeg_pkg.sv
// Shared constants, types and helpers of the life grid stepper.
package lifeg_pkg;

  localparam int GRID_DIM  = 16;
  localparam int OUT_W     = 16;
  localparam int EMIT_ROWS = (GRID_DIM < OUT_W) ? GRID_DIM : OUT_W;
  localparam int CNT_W     = $clog2(GRID_DIM);

  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_STEP  = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  typedef logic [GRID_DIM-1:0] row_t;
  typedef logic [OUT_W-1:0]    out_row_t;

  typedef struct packed {
    logic shift;
    logic write;
  } cell_ctrl_t;

  // Narrow or widen a grid row to the output word, dropping columns past it.
  function automatic out_row_t row_to_out(input row_t row);
    out_row_t res;
    res = '0;
    for (int i = 0; i < OUT_W; i++) begin
      if (i < GRID_DIM) res[i] = row[i];
    end
    return res;
  endfunction

  // Take a written word into a grid row, dropping bits past the grid.
  function automatic row_t out_to_row(input out_row_t word);
    row_t res;
    res = '0;
    for (int i = 0; i < GRID_DIM; i++) begin
      if (i < OUT_W) res[i] = word[i];
    end
    return res;
  endfunction

endpackage

>>> rtl/core/life_automaton_grid_step_core.sv
// Top level of the life grid stepper: row chain, rule unit and result registers.
//
// Usage. Pulse start with an action while busy is low; the word is taken at that
// edge. A write stores row_bits in row row_index and gives no result. A read
// gives one result on the next cycle: the row, the generation count, last = 1.
// A step advances the whole grid one generation by rule B3/S23 with dead
// borders and emits the new rows 0, 1, ... one per cycle, last set on the final
// one, each carrying the incremented generation count.
// Timing. The rows sit in a chain of row cells that rotates one place per cycle
// during a step; the rule unit works on the head of the chain, and busy is high
// until every row has passed it. A taken step first sets the stepping flag, and
// each row then passes through the result registers; the final row shows in the
// cycle that busy falls, and a new item can be taken in that same cycle.
// Results. out_valid_o marks each result for exactly one cycle; the receiver
// must take it then, there is no stall.
// Reset. All cells dead and the generation count zero, effective at once.
module life_automaton_grid_step_core (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               action_i,
  input  logic [3:0]               row_index_i,
  input  lifeg_pkg::out_row_t      row_bits_i,
  output logic                     out_valid_o,
  output logic [3:0]               out_row_index_o,
  output lifeg_pkg::out_row_t      out_row_bits_o,
  output logic [31:0]              generation_o,
  output logic                     last_o
);
  import lifeg_pkg::*;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(GRID_DIM - 1);

  row_t       rows [GRID_DIM];
  cell_ctrl_t ctrl [GRID_DIM];
  row_t       wr_row;
  row_t       new_row;
  row_t       below_row;

  logic             stepping_q, stepping_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  row_t             prev_q, prev_d;
  logic [31:0]      gen_q, gen_d;

  logic             valid_q, valid_d;
  logic [3:0]       oidx_q, oidx_d;
  out_row_t         obits_q, obits_d;
  logic             last_q, last_d;

  logic             accept;
  logic             in_range;
  logic [CNT_W-1:0] idx_ext;

  assign busy     = stepping_q;
  assign accept   = start && !stepping_q;
  assign in_range = int'(row_index_i) < GRID_DIM;
  assign idx_ext  = CNT_W'(row_index_i);
  assign wr_row   = out_to_row(row_bits_i);

  // Bottom row has a dead row below it.
  assign below_row = (cnt_q == CNT_LAST) ? '0 : rows[1 % GRID_DIM];

  lifeg_next_row u_rule (
    .above_i  (prev_q),
    .center_i (rows[0]),
    .below_i  (below_row),
    .next_o   (new_row)
  );

  for (genvar k = 0; k < GRID_DIM; k++) begin : g_cell
    row_t shift_in;
    if (k == GRID_DIM - 1) begin : g_tail
      assign shift_in = new_row;
    end else begin : g_mid
      assign shift_in = rows[k+1];
    end

    assign ctrl[k].shift = stepping_q;
    assign ctrl[k].write = accept && (action_i == ACT_WRITE) && in_range
                           && (idx_ext == CNT_W'(k));

    lifeg_row_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl[k]),
      .wr_row_i    (wr_row),
      .shift_row_i (shift_in),
      .row_o       (rows[k])
    );
  end

  always_comb begin
    stepping_d = stepping_q;
    cnt_d      = cnt_q;
    prev_d     = prev_q;
    gen_d      = gen_q;
    valid_d    = 1'b0;
    oidx_d     = oidx_q;
    obits_d    = obits_q;
    last_d     = last_q;

    if (stepping_q) begin
      // Emit the head row's new value and rotate the chain one place.
      valid_d = int'(cnt_q) < EMIT_ROWS;
      oidx_d  = 4'(cnt_q);
      obits_d = row_to_out(new_row);
      last_d  = int'(cnt_q) == EMIT_ROWS - 1;
      prev_d  = rows[0];
      cnt_d   = cnt_q + 1'b1;
      if (cnt_q == CNT_LAST) begin
        stepping_d = 1'b0;
      end
    end else if (accept) begin
      unique case (action_i)
        ACT_STEP: begin
          stepping_d = 1'b1;
          cnt_d      = '0;
          prev_d     = '0;
          gen_d      = gen_q + 32'd1;
        end
        ACT_READ: begin
          valid_d = 1'b1;
          oidx_d  = row_index_i;
          obits_d = in_range ? row_to_out(rows[idx_ext]) : '0;
          last_d  = 1'b1;
        end
        default: begin
          // Writes go straight to the cells; unused code is dropped.
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stepping_q <= 1'b0;
      cnt_q      <= '0;
      gen_q      <= '0;
      valid_q    <= 1'b0;
    end else begin
      stepping_q <= stepping_d;
      cnt_q      <= cnt_d;
      gen_q      <= gen_d;
      valid_q    <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prev_q  <= prev_d;
    oidx_q  <= oidx_d;
    obits_q <= obits_d;
    last_q  <= last_d;
  end

  assign out_valid_o     = valid_q;
  assign out_row_index_o = oidx_q;
  assign out_row_bits_o  = obits_q;
  assign generation_o    = gen_q;
  assign last_o          = last_q;

endmodule

>>> rtl/core/lifeg_row_cell.sv
// One grid row held in the chain: loads on a write, takes its neighbor's row on a shift.
module lifeg_row_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lifeg_pkg::cell_ctrl_t ctrl_i,
  input  lifeg_pkg::row_t       wr_row_i,
  input  lifeg_pkg::row_t       shift_row_i,
  output lifeg_pkg::row_t       row_o
);
  import lifeg_pkg::*;

  row_t row_q, row_d;

  always_comb begin
    row_d = row_q;
    if (ctrl_i.shift) begin
      row_d = shift_row_i;
    end else if (ctrl_i.write) begin
      row_d = wr_row_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
    end else begin
      row_q <= row_d;
    end
  end

  assign row_o = row_q;

endmodule

>>> rtl/core/lifeg_next_row.sv
// B3/S23 rule for one row, from the rows above, at and below it.
module lifeg_next_row (
  input  lifeg_pkg::row_t above_i,
  input  lifeg_pkg::row_t center_i,
  input  lifeg_pkg::row_t below_i,
  output lifeg_pkg::row_t next_o
);
  import lifeg_pkg::*;

  // Pad with a dead column on each side.
  logic [GRID_DIM+1:0] up_pad, mid_pad, dn_pad;

  assign up_pad  = {1'b0, above_i, 1'b0};
  assign mid_pad = {1'b0, center_i, 1'b0};
  assign dn_pad  = {1'b0, below_i, 1'b0};

  always_comb begin
    logic [3:0] n;
    for (int x = 0; x < GRID_DIM; x++) begin
      n = 4'(up_pad[x]) + 4'(up_pad[x+1]) + 4'(up_pad[x+2])
        + 4'(mid_pad[x]) + 4'(mid_pad[x+2])
        + 4'(dn_pad[x]) + 4'(dn_pad[x+1]) + 4'(dn_pad[x+2]);
      next_o[x] = (n == 4'd3) || (center_i[x] && (n == 4'd2));
    end
  end

endmodule
